[src/pbm_sd_pkg.sv]
// ----------------------------------------------------------------------------
// pbm_sd_pkg
// Types and constants shared by the PBM stream decoder files.
// ----------------------------------------------------------------------------
`default_nettype none

package pbm_sd_pkg;

  localparam int unsigned DATA_W  = 8;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned DIMO_W  = 13;

  // Parser phases
  typedef enum logic [3:0] {
    PH_MAGIC0 = 4'd0,
    PH_MAGIC1 = 4'd1,
    PH_SKIP_W = 4'd2,
    PH_NUM_W  = 4'd3,
    PH_SKIP_H = 4'd4,
    PH_NUM_H  = 4'd5,
    PH_P1     = 4'd6,
    PH_P4     = 4'd7,
    PH_DONE   = 4'd8,
    PH_ERROR  = 4'd9
  } phase_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_RAW    = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  // Error codes carried in the value field
  localparam logic [DATA_W-1:0] ERR_MAGIC     = 8'd0;
  localparam logic [DATA_W-1:0] ERR_NUMBER    = 8'd1;
  localparam logic [DATA_W-1:0] ERR_SIZE      = 8'd2;
  localparam logic [DATA_W-1:0] ERR_PIXEL     = 8'd3;
  localparam logic [DATA_W-1:0] ERR_TRUNCATED = 8'd4;

  // Character codes
  localparam logic [DATA_W-1:0] CH_P     = 8'h50;
  localparam logic [DATA_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [DATA_W-1:0] CH_ONE   = 8'h31;
  localparam logic [DATA_W-1:0] CH_FOUR  = 8'h34;
  localparam logic [DATA_W-1:0] CH_NINE  = 8'h39;
  localparam logic [DATA_W-1:0] CH_HASH  = 8'h23;
  localparam logic [DATA_W-1:0] CH_SPACE = 8'h20;
  localparam logic [DATA_W-1:0] CH_TAB   = 8'h09;
  localparam logic [DATA_W-1:0] CH_CR    = 8'h0D;
  localparam logic [DATA_W-1:0] CH_LF    = 8'h0A;

  typedef struct packed {
    kind_e              kind;
    logic               format;
    logic [DATA_W-1:0]  value;
    logic [POS_W-1:0]   column;
    logic [POS_W-1:0]   row;
    logic [DIMO_W-1:0]  width;
    logic [DIMO_W-1:0]  height;
    logic               last;
  } result_t;

  function automatic logic is_space(input logic [DATA_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_digit(input logic [DATA_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

`default_nettype wire

[src/pbm_sd_if.sv]
// ----------------------------------------------------------------------------
// pbm_sd_byte_if / pbm_sd_result_if
// Valid/ready channels for file bytes in and decoded results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbm_sd_byte_if;
  logic                            valid;
  logic                            ready;
  logic [pbm_sd_pkg::DATA_W-1:0]   data_byte;
  logic                            stream_end;

  modport source (output valid, data_byte, stream_end, input ready);
  modport sink   (input valid, data_byte, stream_end, output ready);
endinterface

interface pbm_sd_result_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      kind;
  logic                            format;
  logic [pbm_sd_pkg::DATA_W-1:0]   value;
  logic [pbm_sd_pkg::POS_W-1:0]    column;
  logic [pbm_sd_pkg::POS_W-1:0]    row;
  logic [pbm_sd_pkg::DIMO_W-1:0]   width;
  logic [pbm_sd_pkg::DIMO_W-1:0]   height;
  logic                            last;

  modport source (output valid, kind, format, value, column, row, width, height, last,
                  input ready);
  modport sink   (input valid, kind, format, value, column, row, width, height, last,
                  output ready);
endinterface

`default_nettype wire

[src/pbm_sd_core.sv]
// ----------------------------------------------------------------------------
// pbm_sd_core
// Parser state and one-byte decision logic: header parse, pixel/byte walk.
// ----------------------------------------------------------------------------
`default_nettype none

module pbm_sd_core #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire logic [pbm_sd_pkg::DATA_W-1:0] data_byte_i,
  input  wire logic                          stream_end_i,
  output logic                               res_valid_o,
  output pbm_sd_pkg::result_t                res_o
);

  localparam int unsigned DimW = $clog2(MAX_DIM + 2);
  localparam int unsigned AccW = DimW + 4;
  localparam logic [DimW-1:0] DimSat  = DimW'(MAX_DIM + 1);
  localparam logic [DimW-1:0] DimMax  = DimW'(MAX_DIM);
  localparam logic [AccW-1:0] DimMaxA = AccW'(MAX_DIM);

  pbm_sd_pkg::phase_e phase_q, phase_d;
  logic               raw_q, raw_d;
  logic               cmt_q, cmt_d;
  logic [DimW-1:0]    acc_q, acc_d;
  logic               tl_q, tl_d;
  logic [DimW-1:0]    wid_q, wid_d;
  logic [DimW-1:0]    hgt_q, hgt_d;
  logic [DimW-1:0]    col_q, col_d;
  logic [DimW-1:0]    row_q, row_d;

  logic               in_num;
  logic [DimW-1:0]    acc_in;
  logic               tl_in;
  logic [AccW-1:0]    acc_mul;
  logic               acc_sat;
  logic [DimW-1:0]    acc_new;
  logic [DimW:0]      row_len;
  logic [DimW:0]      col_inc;
  logic [DimW-1:0]    row_inc;
  logic               row_wrap;
  logic               img_end;
  logic               bad_size;

  // Decimal accumulate with saturation; a new number starts from zero
  always_comb begin
    in_num  = (phase_q == pbm_sd_pkg::PH_NUM_W) || (phase_q == pbm_sd_pkg::PH_NUM_H);
    acc_in  = in_num ? acc_q : '0;
    tl_in   = in_num ? tl_q : 1'b0;
    acc_mul = AccW'({acc_in, 3'b000}) + AccW'({acc_in, 1'b0})
              + AccW'(data_byte_i - pbm_sd_pkg::CH_ZERO);
    acc_sat = tl_in || (acc_mul > DimMaxA);
    acc_new = acc_sat ? DimSat : acc_mul[DimW-1:0];
  end

  // Position walk shared by P1 pixels and P4 bytes
  always_comb begin
    row_len  = (phase_q == pbm_sd_pkg::PH_P4) ? ((DimW+1)'(wid_q) + (DimW+1)'(7)) >> 3
                                              : (DimW+1)'(wid_q);
    col_inc  = (DimW+1)'(col_q) + (DimW+1)'(1);
    row_inc  = row_q + DimW'(1);
    row_wrap = (col_inc >= row_len);
    img_end  = row_wrap && (row_inc >= hgt_q);
    bad_size = (wid_q == '0) || (wid_q > DimMax) || (acc_q == '0) || (acc_q > DimMax);
  end

  // Next state and result
  always_comb begin
    phase_d = phase_q;
    raw_d   = raw_q;
    cmt_d   = cmt_q;
    acc_d   = acc_q;
    tl_d    = tl_q;
    wid_d   = wid_q;
    hgt_d   = hgt_q;
    col_d   = col_q;
    row_d   = row_q;
    res_valid_o   = 1'b0;
    res_o         = '0;
    res_o.format  = raw_q;

    if (stream_end_i) begin
      // End of file: flag truncation unless done or in error, then re-arm
      if (phase_q != pbm_sd_pkg::PH_DONE && phase_q != pbm_sd_pkg::PH_ERROR) begin
        res_valid_o = 1'b1;
        res_o.kind  = pbm_sd_pkg::KIND_ERROR;
        res_o.value = pbm_sd_pkg::ERR_TRUNCATED;
      end
      phase_d = pbm_sd_pkg::PH_MAGIC0;
      raw_d   = 1'b0;
      cmt_d   = 1'b0;
      acc_d   = '0;
      tl_d    = 1'b0;
      wid_d   = '0;
      hgt_d   = '0;
      col_d   = '0;
      row_d   = '0;
    end else begin
      case (phase_q)
        pbm_sd_pkg::PH_MAGIC0: begin
          if (data_byte_i != pbm_sd_pkg::CH_P) begin
            phase_d     = pbm_sd_pkg::PH_ERROR;
            res_valid_o = 1'b1;
            res_o.kind  = pbm_sd_pkg::KIND_ERROR;
            res_o.value = pbm_sd_pkg::ERR_MAGIC;
          end else begin
            phase_d = pbm_sd_pkg::PH_MAGIC1;
          end
        end
        pbm_sd_pkg::PH_MAGIC1: begin
          if (data_byte_i == pbm_sd_pkg::CH_ONE || data_byte_i == pbm_sd_pkg::CH_FOUR) begin
            raw_d   = (data_byte_i == pbm_sd_pkg::CH_FOUR);
            cmt_d   = 1'b0;
            phase_d = pbm_sd_pkg::PH_SKIP_W;
          end else begin
            phase_d     = pbm_sd_pkg::PH_ERROR;
            res_valid_o = 1'b1;
            res_o.kind  = pbm_sd_pkg::KIND_ERROR;
            res_o.value = pbm_sd_pkg::ERR_MAGIC;
          end
        end
        pbm_sd_pkg::PH_SKIP_W, pbm_sd_pkg::PH_SKIP_H: begin
          // Skip whitespace and comments; a digit opens a number, else error
          if (cmt_q) begin
            if (data_byte_i == pbm_sd_pkg::CH_LF) begin
              cmt_d = 1'b0;
            end
          end else if (data_byte_i == pbm_sd_pkg::CH_HASH) begin
            cmt_d = 1'b1;
          end else if (pbm_sd_pkg::is_space(data_byte_i)) begin
            cmt_d = 1'b0;
          end else if (!pbm_sd_pkg::is_digit(data_byte_i)) begin
            phase_d     = pbm_sd_pkg::PH_ERROR;
            res_valid_o = 1'b1;
            res_o.kind  = pbm_sd_pkg::KIND_ERROR;
            res_o.value = pbm_sd_pkg::ERR_NUMBER;
          end else begin
            acc_d   = acc_new;
            tl_d    = acc_sat;
            phase_d = (phase_q == pbm_sd_pkg::PH_SKIP_W) ? pbm_sd_pkg::PH_NUM_W
                                                         : pbm_sd_pkg::PH_NUM_H;
          end
        end
        pbm_sd_pkg::PH_NUM_W: begin
          if (pbm_sd_pkg::is_digit(data_byte_i)) begin
            acc_d = acc_new;
            tl_d  = acc_sat;
          end else begin
            wid_d   = acc_q;
            cmt_d   = 1'b0;
            phase_d = pbm_sd_pkg::PH_SKIP_H;
          end
        end
        pbm_sd_pkg::PH_NUM_H: begin
          if (pbm_sd_pkg::is_digit(data_byte_i)) begin
            acc_d = acc_new;
            tl_d  = acc_sat;
          end else begin
            hgt_d       = acc_q;
            res_valid_o = 1'b1;
            if (bad_size) begin
              phase_d     = pbm_sd_pkg::PH_ERROR;
              res_o.kind  = pbm_sd_pkg::KIND_ERROR;
              res_o.value = pbm_sd_pkg::ERR_SIZE;
            end else begin
              col_d        = '0;
              row_d        = '0;
              phase_d      = raw_q ? pbm_sd_pkg::PH_P4 : pbm_sd_pkg::PH_P1;
              res_o.kind   = pbm_sd_pkg::KIND_HEADER;
              res_o.width  = pbm_sd_pkg::DIMO_W'(wid_q);
              res_o.height = pbm_sd_pkg::DIMO_W'(acc_q);
            end
          end
        end
        pbm_sd_pkg::PH_P1, pbm_sd_pkg::PH_P4: begin
          if (phase_q == pbm_sd_pkg::PH_P1 && pbm_sd_pkg::is_space(data_byte_i)) begin
            res_valid_o = 1'b0;
          end else if (phase_q == pbm_sd_pkg::PH_P1 && data_byte_i != pbm_sd_pkg::CH_ZERO
                       && data_byte_i != pbm_sd_pkg::CH_ONE) begin
            phase_d     = pbm_sd_pkg::PH_ERROR;
            res_valid_o = 1'b1;
            res_o.kind  = pbm_sd_pkg::KIND_ERROR;
            res_o.value = pbm_sd_pkg::ERR_PIXEL;
          end else begin
            // Emit pixel or raw byte and advance the position
            res_valid_o  = 1'b1;
            res_o.kind   = (phase_q == pbm_sd_pkg::PH_P4) ? pbm_sd_pkg::KIND_RAW
                                                          : pbm_sd_pkg::KIND_PIXEL;
            res_o.value  = (phase_q == pbm_sd_pkg::PH_P4) ? data_byte_i
                                                          : {7'd0, data_byte_i[0]};
            res_o.column = pbm_sd_pkg::POS_W'(col_q);
            res_o.row    = pbm_sd_pkg::POS_W'(row_q);
            res_o.width  = pbm_sd_pkg::DIMO_W'(wid_q);
            res_o.height = pbm_sd_pkg::DIMO_W'(hgt_q);
            res_o.last   = img_end;
            if (row_wrap) begin
              col_d = '0;
              row_d = row_inc;
              if (img_end) begin
                phase_d = pbm_sd_pkg::PH_DONE;
              end
            end else begin
              col_d = col_inc[DimW-1:0];
            end
          end
        end
        default: begin
          res_valid_o = 1'b0;
        end
      endcase
    end
  end

  // Parser state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pbm_sd_pkg::PH_MAGIC0;
      raw_q   <= 1'b0;
      cmt_q   <= 1'b0;
      acc_q   <= '0;
      tl_q    <= 1'b0;
      wid_q   <= '0;
      hgt_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      raw_q   <= raw_d;
      cmt_q   <= cmt_d;
      acc_q   <= acc_d;
      tl_q    <= tl_d;
      wid_q   <= wid_d;
      hgt_q   <= hgt_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

endmodule

`default_nettype wire

[src/pbm_stream_decoder.sv]
// ----------------------------------------------------------------------------
// pbm_stream_decoder
// PBM (P1 / P4) byte stream decoder with registered input and result stages.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one file byte per transfer (data_byte), or an end-of-file
//   marker (stream_end = 1, data_byte ignored) that closes the file and
//   re-arms the parser for the next one.
//   out_o carries at most one result per input transfer: a header, a P1
//   pixel, a P4 raw byte, or an error code. Bytes that only advance the
//   parser (magic, digits, whitespace, comments, trailing bytes) give none.
//   Path: a result reaches out_o through the input register, then the
//   result register.
//   Throughput: one byte per cycle while out_o is not held; the per-byte
//   decision is a single pass of logic between input and result registers.
//   Reset: the parser waits for the first magic byte; both stages empty.
//   Stall: while out_o is held, the result register keeps its value and
//   one more byte can wait in the input register; in_i.ready drops only
//   when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module pbm_stream_decoder #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  pbm_sd_byte_if.sink           in_i,
  pbm_sd_result_if.source       out_o
);

  logic                          in_vld_q;
  logic [pbm_sd_pkg::DATA_W-1:0] in_byte_q;
  logic                          in_end_q;
  logic                          out_vld_q;
  pbm_sd_pkg::result_t           out_q;

  logic                          adv;
  logic                          in_rdy;
  logic                          step;
  logic                          core_vld;
  pbm_sd_pkg::result_t           core_res;

  // Stage control: the result register frees up when empty or taken
  assign adv    = !out_vld_q || out_o.ready;
  assign in_rdy = !in_vld_q || adv;
  assign step   = in_vld_q && adv;
  assign in_i.ready = in_rdy;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_rdy) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && in_i.valid) begin
      in_byte_q <= in_i.data_byte;
      in_end_q  <= in_i.stream_end;
    end
  end

  pbm_sd_core #(
    .MAX_DIM (MAX_DIM)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .data_byte_i  (in_byte_q),
    .stream_end_i (in_end_q),
    .res_valid_o  (core_vld),
    .res_o        (core_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= step && core_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= core_res;
    end
  end

  assign out_o.valid  = out_vld_q;
  assign out_o.kind   = out_q.kind;
  assign out_o.format = out_q.format;
  assign out_o.value  = out_q.value;
  assign out_o.column = out_q.column;
  assign out_o.row    = out_q.row;
  assign out_o.width  = out_q.width;
  assign out_o.height = out_q.height;
  assign out_o.last   = out_q.last;

  // A waiting byte holds while the result register is blocked
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !adv |=> in_vld_q && $stable(in_byte_q) && $stable(in_end_q))
    else $error("input register lost a byte under stall");

  // An empty result register never blocks the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> in_rdy)
    else $error("input stalled with empty result register");

  // A stalled result keeps its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_o.ready |=> out_vld_q && $stable(out_q))
    else $error("result register changed under stall");

endmodule

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PBM stream decoder. A directed table walks the
// error paths, a small P4 image and a P1 image. Random files then follow:
// well-formed headers with comments, blanks, leading zeros and odd
// terminators, plus truncated, corrupted and noise files. Every accepted byte
// runs through a local decoder model. Each result transfer is compared field
// by field with the oldest expected result. Both channels idle in random
// bursts, except in the run's closing stretch and in some random files.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int DIM_LIMIT  = 4096;
  localparam int RAND_ITEMS = 780;
  localparam int QUIET_TAIL = 150;
  localparam int DIR_ROWS   = 38;

  // One row of the directed table; code and fmt are used only when the row
  // carries a hand-written error result
  typedef struct packed {
    logic [7:0] data;
    logic       eof;
    logic       tabled;
    logic       fmt;
    logic [7:0] code;
  } dir_row_t;

  typedef struct packed {
    logic                on;
    pbm_sd_pkg::result_t r;
  } tabled_exp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pbm_sd_byte_if   in_if ();
  pbm_sd_result_if res_if ();

  pbm_stream_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (res_if)
  );

  always #1 clk_i = ~clk_i;

  // Decoder model state
  pbm_sd_pkg::phase_e dec_phase;
  logic               dec_raw;
  logic               dec_comment;
  logic [12:0]        dec_acc;
  logic               dec_big;
  logic [12:0]        image_w;
  logic [12:0]        image_h;
  logic [12:0]        col_cnt;
  logic [12:0]        row_cnt;

  pbm_sd_pkg::result_t pending_results[$];
  tabled_exp_t         tabled_q[$];
  logic [7:0]          file_q[$];

  bit idling_enabled = 1'b1;
  int failures   = 0;
  int bytes_in   = 0;
  int files_sent = 0;
  int n_header   = 0;
  int n_pixel    = 0;
  int n_raw      = 0;
  int n_error    = 0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // empty file, then bad second magic byte and bytes ignored after it
    '{8'h00, 1'b1, 1'b1, 1'b0, pbm_sd_pkg::ERR_TRUNCATED},
    '{pbm_sd_pkg::CH_P,  1'b0, 1'b0, 1'b0, 8'h00},
    '{8'hFF, 1'b0, 1'b1, 1'b0, pbm_sd_pkg::ERR_MAGIC},
    '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'hFF, 1'b1, 1'b0, 1'b0, 8'h00},
    // bad character where a number should start
    '{pbm_sd_pkg::CH_P,  1'b0, 1'b0, 1'b0, 8'h00},
    '{pbm_sd_pkg::CH_ONE, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'h78, 1'b0, 1'b1, 1'b0, pbm_sd_pkg::ERR_NUMBER},
    '{8'h00, 1'b1, 1'b0, 1'b0, 8'h00},
    // P4 1x2 with NUL as the height terminator and a byte after the image
    '{pbm_sd_pkg::CH_P,  1'b0, 1'b0, 1'b0, 8'h00},
    '{pbm_sd_pkg::CH_FOUR, 1'b0, 1'b0, 1'b0, 8'h00},
    '{pbm_sd_pkg::CH_ONE, 1'b0, 1'b0, 1'b0, 8'h00},
    '{pbm_sd_pkg::CH_LF, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'h32, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'h41, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'h00, 1'b1, 1'b0, 1'b0, 8'h00},
    // width 9999 saturates and fails the size check
    '{pbm_sd_pkg::CH_P,  1'b0, 1'b0, 1'b0, 8'h00},
    '{pbm_sd_pkg::CH_ONE, 1'b0, 1'b0, 1'b0, 8'h00},
    '{pbm_sd_pkg::CH_NINE, 1'b0, 1'b0, 1'b0, 8'h00},
    '{pbm_sd_pkg::CH_NINE, 1'b0, 1'b0, 1'b0, 8'h00},
    '{pbm_sd_pkg::CH_NINE, 1'b0, 1'b0, 1'b0, 8'h00},
    '{pbm_sd_pkg::CH_NINE, 1'b0, 1'b0, 1'b0, 8'h00},
    '{pbm_sd_pkg::CH_TAB, 1'b0, 1'b0, 1'b0, 8'h00},
    '{pbm_sd_pkg::CH_ONE, 1'b0, 1'b0, 1'b0, 8'h00},
    '{pbm_sd_pkg::CH_SPACE, 1'b0, 1'b1, 1'b0, pbm_sd_pkg::ERR_SIZE},
    '{8'h00, 1'b1, 1'b0, 1'b0, 8'h00},
    // P1 2x1: one good pixel, then a bad one
    '{pbm_sd_pkg::CH_P,  1'b0, 1'b0, 1'b0, 8'h00},
    '{pbm_sd_pkg::CH_ONE, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'h32, 1'b0, 1'b0, 1'b0, 8'h00},
    '{pbm_sd_pkg::CH_SPACE, 1'b0, 1'b0, 1'b0, 8'h00},
    '{pbm_sd_pkg::CH_ONE, 1'b0, 1'b0, 1'b0, 8'h00},
    '{pbm_sd_pkg::CH_CR, 1'b0, 1'b0, 1'b0, 8'h00},
    '{pbm_sd_pkg::CH_ONE, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'h37, 1'b0, 1'b1, 1'b0, pbm_sd_pkg::ERR_PIXEL},
    '{8'h00, 1'b1, 1'b0, 1'b0, 8'h00}
  };

  // --------------------------------------------------------------------------
  // Decoder model
  // --------------------------------------------------------------------------
  function automatic bit is_blank(input logic [7:0] c);
    return c == pbm_sd_pkg::CH_SPACE || c == pbm_sd_pkg::CH_TAB ||
           c == pbm_sd_pkg::CH_CR || c == pbm_sd_pkg::CH_LF;
  endfunction

  function automatic bit is_numeral(input logic [7:0] c);
    return c >= pbm_sd_pkg::CH_ZERO && c <= pbm_sd_pkg::CH_NINE;
  endfunction

  function automatic void clear_decoder();
    dec_phase   = pbm_sd_pkg::PH_MAGIC0;
    dec_raw     = 1'b0;
    dec_comment = 1'b0;
    dec_acc     = '0;
    dec_big     = 1'b0;
    image_w     = '0;
    image_h     = '0;
    col_cnt     = '0;
    row_cnt     = '0;
  endfunction

  function automatic void fail_with(input logic [7:0] code, output pbm_sd_pkg::result_t r);
    dec_phase = pbm_sd_pkg::PH_ERROR;
    r         = '0;
    r.kind    = pbm_sd_pkg::KIND_ERROR;
    r.format  = dec_raw;
    r.value   = code;
  endfunction

  function automatic pbm_sd_pkg::result_t data_result(input pbm_sd_pkg::kind_e k,
                                                      input logic [7:0] v,
                                                      input logic [12:0] col,
                                                      input logic [12:0] row,
                                                      input logic last);
    pbm_sd_pkg::result_t r;
    r.kind   = k;
    r.format = dec_raw;
    r.value  = v;
    r.column = col[11:0];
    r.row    = row[11:0];
    r.width  = image_w;
    r.height = image_h;
    r.last   = last;
    return r;
  endfunction

  // Saturate one past the limit once the number grows too large
  function automatic void count_digit(input logic [7:0] c);
    int v;
    v = int'(dec_acc) * 10 + int'(c) - int'(pbm_sd_pkg::CH_ZERO);
    if (dec_big || v > DIM_LIMIT) begin
      dec_big = 1'b1;
      v       = DIM_LIMIT + 1;
    end
    dec_acc = 13'(v);
  endfunction

  // Skip blanks and comments ahead of a number; a digit opens the number
  function automatic void skip_gap(input logic [7:0] c, input pbm_sd_pkg::phase_e next,
                                   output bit got, output pbm_sd_pkg::result_t r);
    got = 1'b0;
    r   = '0;
    if (dec_comment) begin
      if (c == pbm_sd_pkg::CH_LF) dec_comment = 1'b0;
    end else if (c == pbm_sd_pkg::CH_HASH) begin
      dec_comment = 1'b1;
    end else if (!is_blank(c)) begin
      if (!is_numeral(c)) begin
        fail_with(pbm_sd_pkg::ERR_NUMBER, r);
        got = 1'b1;
      end else begin
        dec_acc   = '0;
        dec_big   = 1'b0;
        count_digit(c);
        dec_phase = next;
      end
    end
  endfunction

  function automatic void step_position(input logic [12:0] len, output logic last);
    last = 1'b0;
    if (col_cnt + 13'd1 >= len) begin
      col_cnt = '0;
      row_cnt = row_cnt + 13'd1;
      if (row_cnt >= image_h) begin
        last      = 1'b1;
        dec_phase = pbm_sd_pkg::PH_DONE;
      end
    end else begin
      col_cnt = col_cnt + 13'd1;
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] c, input logic eof,
                                      output bit got, output pbm_sd_pkg::result_t r);
    logic [12:0] col;
    logic [12:0] row;
    logic        last;
    got = 1'b0;
    r   = '0;
    if (eof) begin
      if (dec_phase != pbm_sd_pkg::PH_DONE && dec_phase != pbm_sd_pkg::PH_ERROR) begin
        fail_with(pbm_sd_pkg::ERR_TRUNCATED, r);
        got = 1'b1;
      end
      clear_decoder();
      return;
    end
    case (dec_phase)
      pbm_sd_pkg::PH_MAGIC0: begin
        if (c != pbm_sd_pkg::CH_P) begin
          fail_with(pbm_sd_pkg::ERR_MAGIC, r);
          got = 1'b1;
        end else begin
          dec_phase = pbm_sd_pkg::PH_MAGIC1;
        end
      end
      pbm_sd_pkg::PH_MAGIC1: begin
        if (c == pbm_sd_pkg::CH_ONE || c == pbm_sd_pkg::CH_FOUR) begin
          dec_raw     = (c == pbm_sd_pkg::CH_FOUR);
          dec_comment = 1'b0;
          dec_phase   = pbm_sd_pkg::PH_SKIP_W;
        end else begin
          fail_with(pbm_sd_pkg::ERR_MAGIC, r);
          got = 1'b1;
        end
      end
      pbm_sd_pkg::PH_SKIP_W: skip_gap(c, pbm_sd_pkg::PH_NUM_W, got, r);
      pbm_sd_pkg::PH_NUM_W: begin
        if (is_numeral(c)) begin
          count_digit(c);
        end else begin
          image_w     = dec_acc;
          dec_comment = 1'b0;
          dec_phase   = pbm_sd_pkg::PH_SKIP_H;
        end
      end
      pbm_sd_pkg::PH_SKIP_H: skip_gap(c, pbm_sd_pkg::PH_NUM_H, got, r);
      pbm_sd_pkg::PH_NUM_H: begin
        if (is_numeral(c)) begin
          count_digit(c);
        end else begin
          image_h = dec_acc;
          got     = 1'b1;
          if (image_w == 0 || image_w > DIM_LIMIT || image_h == 0 || image_h > DIM_LIMIT) begin
            fail_with(pbm_sd_pkg::ERR_SIZE, r);
          end else begin
            col_cnt   = '0;
            row_cnt   = '0;
            dec_phase = dec_raw ? pbm_sd_pkg::PH_P4 : pbm_sd_pkg::PH_P1;
            r         = data_result(pbm_sd_pkg::KIND_HEADER, 8'h00, '0, '0, 1'b0);
          end
        end
      end
      pbm_sd_pkg::PH_P1: begin
        if (!is_blank(c)) begin
          got = 1'b1;
          if (c != pbm_sd_pkg::CH_ZERO && c != pbm_sd_pkg::CH_ONE) begin
            fail_with(pbm_sd_pkg::ERR_PIXEL, r);
          end else begin
            col = col_cnt;
            row = row_cnt;
            step_position(image_w, last);
            r = data_result(pbm_sd_pkg::KIND_PIXEL, c - pbm_sd_pkg::CH_ZERO, col, row, last);
          end
        end
      end
      pbm_sd_pkg::PH_P4: begin
        col = col_cnt;
        row = row_cnt;
        step_position((image_w + 13'd7) >> 3, last);
        r   = data_result(pbm_sd_pkg::KIND_RAW, c, col, row, last);
        got = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // File builder
  // --------------------------------------------------------------------------
  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0:       return pbm_sd_pkg::CH_SPACE;
      1:       return pbm_sd_pkg::CH_TAB;
      2:       return pbm_sd_pkg::CH_CR;
      default: return pbm_sd_pkg::CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Blanks and comments ahead of a number, possibly none
  task automatic add_gap();
    logic [7:0] t;
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 3) == 0) begin
        file_q.push_back(pbm_sd_pkg::CH_HASH);
        repeat ($urandom_range(0, 5)) begin
          do t = any_byte(); while (t == pbm_sd_pkg::CH_LF);
          file_q.push_back(t);
        end
        file_q.push_back(pbm_sd_pkg::CH_LF);
      end else begin
        file_q.push_back(pick_blank());
      end
    end
  endtask

  // Optional leading zeros and decimal digits, then one non-digit terminator
  task automatic add_number(input int v);
    string      s;
    logic [7:0] t;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 2)) file_q.push_back(pbm_sd_pkg::CH_ZERO);
    end
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) file_q.push_back(8'(s[i]));
    if ($urandom_range(0, 3) != 0) begin
      file_q.push_back(pick_blank());
    end else begin
      do t = any_byte(); while (is_numeral(t));
      file_q.push_back(t);
    end
  endtask

  // Negative arguments pick the size and format at random
  task automatic build_file(input int fw, input int fh, input int fraw, output int trailing);
    int w;
    int h;
    int k;
    int pick;
    bit raw;
    file_q.delete();
    trailing = 0;
    raw = (fraw < 0) ? 1'($urandom_range(0, 1)) : 1'(fraw);
    if (fw >= 0) begin
      w = fw;
      h = fh;
    end else begin
      w = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 10) : $urandom_range(11, 40);
      h = $urandom_range(1, 4);
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0:       pick = 0;
          1:       pick = DIM_LIMIT + 1;
          2:       pick = 65535;
          default: pick = 123456;
        endcase
        if ($urandom_range(0, 1) == 1) w = pick;
        else h = pick;
      end
    end
    file_q.push_back(pbm_sd_pkg::CH_P);
    file_q.push_back(raw ? pbm_sd_pkg::CH_FOUR : pbm_sd_pkg::CH_ONE);
    add_gap();
    add_number(w);
    add_gap();
    add_number(h);
    if (w >= 1 && w <= DIM_LIMIT && h >= 1 && h <= DIM_LIMIT) begin
      if (raw) begin
        repeat (((w + 7) / 8) * h) file_q.push_back(any_byte());
      end else begin
        for (k = 0; k < w * h; k++) begin
          if ($urandom_range(0, 3) == 0) file_q.push_back(pick_blank());
          file_q.push_back($urandom_range(0, 1) == 1 ? pbm_sd_pkg::CH_ONE
                                                     : pbm_sd_pkg::CH_ZERO);
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        trailing = $urandom_range(1, 4);
        repeat (trailing) file_q.push_back(any_byte());
      end
    end
    // Break about a third of the random files
    if (fw < 0 && $urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          k = $urandom_range(0, file_q.size() - 1);
          while (file_q.size() > k) void'(file_q.pop_back());
        end
        1: file_q[$urandom_range(0, file_q.size() - 1)] = any_byte();
        2: file_q.insert($urandom_range(0, file_q.size()), any_byte());
        default: begin
          file_q.delete();
          repeat ($urandom_range(1, 8)) file_q.push_back(any_byte());
        end
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Byte sender
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [7:0] b, input logic eof, input tabled_exp_t te);
    if (idling_enabled && $urandom_range(0, 9) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    tabled_q.push_back(te);
    in_if.valid      <= 1'b1;
    in_if.data_byte  <= b;
    in_if.stream_end <= eof;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_item(file_q[i], 1'b0, '0);
    send_item(any_byte(), 1'b1, '0);
    files_sent++;
  endtask

  // Hold the sender until every expected result has come back
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Result receiver: random stall bursts
  // --------------------------------------------------------------------------
  initial begin
    res_if.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (idling_enabled && $urandom_range(0, 7) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        res_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Transfer monitor and checker
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned seen);
    if (want != seen) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, seen);
      failures++;
    end
  endfunction

  always @(posedge clk_i) begin : watch
    tabled_exp_t         te;
    pbm_sd_pkg::result_t want;
    pbm_sd_pkg::result_t model_r;
    bit                  got;
    if (rst_ni) begin
      // Predict on every accepted byte transfer
      if (in_if.valid && in_if.ready) begin
        te = tabled_q.pop_front();
        decode_byte(in_if.data_byte, in_if.stream_end, got, model_r);
        if (te.on) pending_results.push_back(te.r);
        else if (got) pending_results.push_back(model_r);
        bytes_in++;
      end
      // Compare every result transfer with the oldest expectation
      if (res_if.valid && res_if.ready) begin
        case (res_if.kind)
          pbm_sd_pkg::KIND_HEADER: n_header++;
          pbm_sd_pkg::KIND_PIXEL:  n_pixel++;
          pbm_sd_pkg::KIND_RAW:    n_raw++;
          default:                 n_error++;
        endcase
        if (pending_results.size() == 0) begin
          $error("unexpected result: kind %0d value %0d", res_if.kind, res_if.value);
          failures++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind",   32'(want.kind),   32'(res_if.kind));
          check_field("format", 32'(want.format), 32'(res_if.format));
          check_field("value",  32'(want.value),  32'(res_if.value));
          check_field("column", 32'(want.column), 32'(res_if.column));
          check_field("row",    32'(want.row),    32'(res_if.row));
          check_field("width",  32'(want.width),  32'(res_if.width));
          check_field("height", 32'(want.height), 32'(res_if.height));
          check_field("last",   32'(want.last),   32'(res_if.last));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    tabled_exp_t te;
    int          trailing;
    int          random_items;
    clear_decoder();
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.data_byte  <= '0;
    in_if.stream_end <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      te          = '0;
      te.on       = dir_rows[i].tabled;
      te.r.kind   = pbm_sd_pkg::KIND_ERROR;
      te.r.format = dir_rows[i].fmt;
      te.r.value  = dir_rows[i].code;
      send_item(dir_rows[i].data, dir_rows[i].eof, te);
    end
    drain_results();

    // Widest image once: a 4096-pixel P4 row
    build_file(DIM_LIMIT, 1, 1, trailing);
    send_file();

    // Random files, quiet at the end
    random_items = 0;
    while (random_items < RAND_ITEMS) begin
      idling_enabled = (random_items < RAND_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      build_file(-1, -1, -1, trailing);
      random_items += file_q.size() + 1 - trailing;
      send_file();
      if (files_sent % 8 == 0) drain_results();
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d files, %0d byte transfers, including a P4 image 4096 pixels wide.",
             files_sent, bytes_in);
    $display("Results checked: %0d headers, %0d pixels, %0d raw bytes, %0d errors.",
             n_header, n_pixel, n_raw, n_error);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[pbm_stream_decoder.f]
src/pbm_sd_pkg.sv
src/pbm_sd_if.sv
src/pbm_sd_core.sv
src/pbm_stream_decoder.sv
tb/tb_top.sv
